// ===== rtl/tdf_pkg.sv =====
// Package: sizes, field widths and shared constants of the tolerance duplicate filter.
`default_nettype none
package tdf_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int VALUE_W     = 32;
    localparam int TOL_W       = 32;
    localparam int SLOT_W      = 8;
    localparam int UCNT_W      = 9;
    localparam int DCNT_W      = 16;
    localparam int DIFF_W      = VALUE_W + 1;
    localparam int PROD_W      = TOL_W + VALUE_W;
    localparam int FRAC_W      = 16;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

endpackage
`default_nettype wire

// ===== rtl/tdf_if.sv =====
// Interfaces: input word channel and result word channel with valid/ready handshake.
`default_nettype none
interface tdf_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [tdf_pkg::VALUE_W-1:0]    value;
    logic                                  last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface tdf_out_if;
    logic                           valid;
    logic                           ready;
    logic                           is_unique;
    logic [tdf_pkg::SLOT_W-1:0]     slot;
    logic [tdf_pkg::UCNT_W-1:0]     unique_count;
    logic [tdf_pkg::DCNT_W-1:0]     duplicate_count;
    logic                           overflow;
    logic                           end_of_set;

    modport source (output valid, output is_unique, output slot, output unique_count,
                    output duplicate_count, output overflow, output end_of_set,
                    input ready);
    modport sink   (input valid, input is_unique, input slot, input unique_count,
                    input duplicate_count, input overflow, input end_of_set,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/tdf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module tdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tdf_match.sv =====
// Tolerance test unit: holds the fresh word and tolerance*|value|, tests one kept word a cycle.
`default_nettype none
module tdf_match (
    input  wire logic                               clk,
    input  wire logic                               load,
    input  wire logic [tdf_pkg::TOL_W-1:0]          tolerance,
    input  wire logic signed [tdf_pkg::VALUE_W-1:0] value,
    input  wire logic [tdf_pkg::VALUE_W-1:0]        kept,
    output logic [tdf_pkg::VALUE_W-1:0]             fresh,
    output logic                                    hit
);

    logic [tdf_pkg::VALUE_W-1:0] fresh_reg;
    logic [tdf_pkg::PROD_W-1:0]  prod_reg;
    logic [tdf_pkg::TOL_W-1:0]   tol_reg;
    logic [tdf_pkg::VALUE_W-1:0] mag_in;
    logic signed [tdf_pkg::DIFF_W-1:0] diff;
    logic [tdf_pkg::DIFF_W-1:0]  abs_diff;
    logic [tdf_pkg::PROD_W-1:0]  dist_scaled;

    // |value| fits 32 unsigned bits, the most negative code included
    assign mag_in = value[tdf_pkg::VALUE_W-1] ? (~value + 1'b1) : value;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fresh_reg <= value;
            tol_reg   <= tolerance;
            prod_reg  <= tdf_pkg::PROD_W'(tolerance) * tdf_pkg::PROD_W'(mag_in);
        end
    end

    always_comb
    begin
        diff = {fresh_reg[tdf_pkg::VALUE_W-1], fresh_reg}
             - {kept[tdf_pkg::VALUE_W-1], kept};
        abs_diff = diff[tdf_pkg::DIFF_W-1] ? (~diff + 1'b1) : diff;
        dist_scaled = tdf_pkg::PROD_W'({abs_diff, {tdf_pkg::FRAC_W{1'b0}}});
        hit = (abs_diff < tdf_pkg::DIFF_W'(tol_reg)) || (dist_scaled < prod_reg);
    end

    assign fresh = fresh_reg;

endmodule
`default_nettype wire

// ===== rtl/tolerance_duplicate_filter.sv =====
// Top level: sequencer, kept-value store and result register of the tolerance duplicate filter.
//
// Takes a set of signed Q16.16 words, one per input word, and reports for each
// whether it lies within tolerance of any word kept earlier in the same set
// (absolute test |d| < tol, or relative test |d| < tol*|value|, both strict).
// Unique words are appended to a 256-entry store and their slot is reported;
// every result carries the running unique and saturating duplicate counts, and
// a word with last set closes the set and clears the counts. A unique word that
// finds the store full is reported with overflow and not kept. One input word
// is handled at a time: the scan makes one store read per cycle over the kept
// words between the accept and finish steps, and a match ends the scan early.
// The single read port of the store sets this pace. A finished result sits in
// the output register while the next word is accepted and scanned; only the
// finish step waits for it to be taken. No clearing pass is needed after reset.
// Tolerance is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle, as the block itself does not enforce this;
// zero tolerance makes every word unique.
`default_nettype none
module tolerance_duplicate_filter (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [tdf_pkg::TOL_W-1:0]  cfg_wr_data,
    tdf_in_if.sink                          items,
    tdf_out_if.source                       results
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t                         state_reg;
    logic [tdf_pkg::TOL_W-1:0]      tolerance_reg;
    logic [tdf_pkg::CNT_W-1:0]      kept_cnt_reg;
    logic [tdf_pkg::DCNT_W-1:0]     dup_cnt_reg;
    logic [tdf_pkg::CNT_W-1:0]      rd_idx_reg;
    logic                           rvalid_reg;
    logic                           found_reg;
    logic                           last_reg;

    logic                           out_valid_reg;
    logic                           out_unique_reg;
    logic [tdf_pkg::SLOT_W-1:0]     out_slot_reg;
    logic [tdf_pkg::UCNT_W-1:0]     out_ucnt_reg;
    logic [tdf_pkg::DCNT_W-1:0]     out_dcnt_reg;
    logic                           out_ovf_reg;
    logic                           out_eos_reg;

    logic                           accept;
    logic                           issue;
    logic                           hit;
    logic                           emit;
    logic                           store_ok;
    logic [tdf_pkg::CNT_W-1:0]      kept_after;
    logic [tdf_pkg::DCNT_W-1:0]     dup_after;
    logic [31:0]                    slot_wide;
    logic [31:0]                    ucnt_wide;
    logic [tdf_pkg::VALUE_W-1:0]    fresh;
    logic [tdf_pkg::VALUE_W-1:0]    kept_word;

    // Accept a new word only between items; the result register is separate.
    assign items.ready = (state_reg == ST_IDLE);
    assign accept      = items.valid && items.ready;

    // Issue one store read per scan cycle until every kept word is requested.
    assign issue = (state_reg == ST_SCAN) && (rd_idx_reg < kept_cnt_reg);

    // Finish once the result register is free or being emptied.
    assign emit = (state_reg == ST_FINISH) && (!out_valid_reg || results.ready);

    always_comb
    begin
        store_ok   = !found_reg && (kept_cnt_reg < tdf_pkg::MAX_CNT);
        kept_after = store_ok ? (kept_cnt_reg + 1'b1) : kept_cnt_reg;
        dup_after  = (found_reg && (dup_cnt_reg != '1)) ? (dup_cnt_reg + 1'b1) : dup_cnt_reg;
        slot_wide  = store_ok ? 32'(kept_cnt_reg) : 32'd0;
        ucnt_wide  = 32'(kept_after);
    end

    tdf_ram #(
        .WIDTH (tdf_pkg::VALUE_W),
        .DEPTH (tdf_pkg::MAX_ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (emit && store_ok),
        .waddr (kept_cnt_reg[tdf_pkg::ADDR_W-1:0]),
        .wdata (fresh),
        .re    (issue),
        .raddr (rd_idx_reg[tdf_pkg::ADDR_W-1:0]),
        .rdata (kept_word)
    );

    tdf_match u_match (
        .clk       (clk),
        .load      (accept),
        .tolerance (tolerance_reg),
        .value     (items.value),
        .kept      (kept_word),
        .fresh     (fresh),
        .hit       (hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            tolerance_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            kept_cnt_reg   <= '0;
            dup_cnt_reg    <= '0;
            rd_idx_reg     <= '0;
            rvalid_reg     <= 1'b0;
            found_reg      <= 1'b0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_unique_reg <= 1'b0;
            out_slot_reg   <= '0;
            out_ucnt_reg   <= '0;
            out_dcnt_reg   <= '0;
            out_ovf_reg    <= 1'b0;
            out_eos_reg    <= 1'b0;
        end
        else
        begin
            // Drop the result once it has been taken, unless a new one replaces it.
            if (out_valid_reg && results.ready && !emit)
            begin
                out_valid_reg <= 1'b0;
            end

            rvalid_reg <= issue;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg   <= items.last;
                        rd_idx_reg <= '0;
                        found_reg  <= 1'b0;
                        state_reg  <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    if (issue)
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                    // A hit on the returning word ends the scan; reads in flight are ignored.
                    if (rvalid_reg && hit)
                    begin
                        found_reg <= 1'b1;
                        state_reg <= ST_FINISH;
                    end
                    else if (!issue)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end

                ST_FINISH:
                begin
                    if (emit)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_unique_reg <= !found_reg;
                        out_slot_reg   <= slot_wide[tdf_pkg::SLOT_W-1:0];
                        out_ucnt_reg   <= ucnt_wide[tdf_pkg::UCNT_W-1:0];
                        out_dcnt_reg   <= dup_after;
                        out_ovf_reg    <= !found_reg && !store_ok;
                        out_eos_reg    <= last_reg;
                        // Close the set after its last word.
                        kept_cnt_reg   <= last_reg ? '0 : kept_after;
                        dup_cnt_reg    <= last_reg ? '0 : dup_after;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.is_unique       = out_unique_reg;
    assign results.slot            = out_slot_reg;
    assign results.unique_count    = out_ucnt_reg;
    assign results.duplicate_count = out_dcnt_reg;
    assign results.overflow        = out_ovf_reg;
    assign results.end_of_set      = out_eos_reg;

    // The store never holds more words than it has entries.
    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_cnt_reg <= tdf_pkg::MAX_CNT)
        else $error("kept count beyond store depth");

    // Read data is only expected back in the cycle after a scan read.
    a_rvalid_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg |-> $past(state_reg == ST_SCAN))
        else $error("store read returned outside a scan");

    // A duplicate result reports no slot and no overflow.
    a_dup_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.is_unique) |-> (results.slot == '0 && !results.overflow))
        else $error("duplicate result with slot or overflow");

    // A new word is never taken while the previous one is still in flight.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_FINISH) |-> !items.ready)
        else $error("input ready while an item is in flight");

endmodule
`default_nettype wire
